/* rtl/core/edns_pkg.sv */
// Package for the Euclidean distance block with Newton square root.
// Holds widths, register indexes, the sequencer state type and the control struct.
// No dependencies.
`timescale 1ns / 1ps
package edns_pkg;

  localparam int CoordW = 16;
  localparam int SumW   = 34;
  localparam int WW     = 50;
  localparam int RootW  = 32;
  localparam int SqW    = 64;
  localparam int DistW  = 25;
  localparam int StepW  = 6;
  localparam int TolW   = 32;
  localparam int CfgIdxW = 1;
  localparam int QuoW   = 64;

  localparam logic [CfgIdxW-1:0] RegTolerance = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxIter   = 1'b1;

  localparam logic [TolW-1:0]  TolReset  = 32'd42950;
  localparam logic [StepW-1:0] IterReset = 6'd20;
  localparam logic [DistW-1:0] DistMax   = {DistW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_START,
    ST_CHECK_LIMIT,
    ST_ERR0,
    ST_DIVIDE,
    ST_UPDATE,
    ST_ERR1,
    ST_DONE
  } seq_state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic            start;
    logic [QuoW-1:0] dividend;
    logic [QuoW-1:0] divisor;
  } div_req_t;

endpackage

/* rtl/core/euclidean_distance_newton_sqrt.sv */
// Top level of the Euclidean distance block with a Newton square root.
// Depends on edns_pkg and edns_div.
//
// Use: an item of four signed Q8.8 coordinates enters on in_valid while
// in_stall is low. The block forms the exact sum of squared differences V
// and takes its square root by Newton steps r <- r + (W - r*r)/(2r), with
// W = V << 16, starting from V/10, until |W - r*r| is within the tolerance
// register or max_iterations steps have been made. The result item carries
// the distance with 16 fraction bits, the steps used and a converged flag.
// Rate: one item at a time. Each step includes a division by the bit-serial
// divider. The one shared multiplier forms the squares and r*r; the start
// value V/10 also goes through the shared divider. A zero sum skips the
// divider and the Newton steps and goes straight to the result.
// The input stays stalled from acceptance until the result has been taken;
// while the receiver holds out_stall high the result is held unchanged.
// Reset restores tolerance to 42950 and max_iterations to 20 and empties
// the block. Configuration is written through cfg_we, cfg_index, cfg_data.
`timescale 1ns / 1ps
module euclidean_distance_newton_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [edns_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [edns_pkg::TolW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_p1_x,
  input  logic signed [15:0]            in_p1_y,
  input  logic signed [15:0]            in_p2_x,
  input  logic signed [15:0]            in_p2_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [edns_pkg::DistW-1:0]    out_distance,
  output logic [edns_pkg::StepW-1:0]    out_steps_used,
  output logic                          out_converged
);
  import edns_pkg::*;

  // Configuration registers.
  logic [TolW-1:0]  tol_r;
  logic [StepW-1:0] max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= TolReset;
      max_iter_r <= IterReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegTolerance: tol_r      <= cfg_data;
        RegMaxIter:   max_iter_r <= cfg_data[StepW-1:0];
        default:      ;
      endcase
    end
  end

  seq_state_t state_r, state_nxt;

  // Difference magnitudes fit in 16 bits; the registers are 17 bits wide.
  logic [16:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SumW-1:0]  v_r, v_nxt;
  logic [RootW-1:0] r_r, r_nxt;
  logic signed [SqW:0] e_r, e_nxt;
  logic [StepW-1:0] steps_r, steps_nxt;
  logic             conv_r, conv_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             div_pend_r, div_pend_nxt;
  logic             start_div_r, start_div_nxt;

  // Shared multiplier: one 32x32 product, operands chosen by the sequencer.
  logic [RootW-1:0] mul_a;
  logic [SqW-1:0]   prod;

  div_req_t         dreq;
  logic             div_busy;
  logic [QuoW-1:0]  quo;

  edns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .busy     (div_busy),
    .quotient (quo)
  );

  logic signed [16:0] dxs, dys;
  logic [QuoW-1:0]    emag;
  logic [QuoW-1:0]    step_mag;
  logic [RootW:0]     r_new;

  always_comb begin
    dxs = 17'(in_p1_x) - 17'(in_p2_x);
    dys = 17'(in_p1_y) - 17'(in_p2_y);
    case (state_r)
      ST_SQ1:  mul_a = {15'd0, dx_r};
      ST_SQ2:  mul_a = {15'd0, dy_r};
      default: mul_a = r_r;
    endcase
    prod = SqW'(mul_a) * SqW'(mul_a);
  end

  always_comb begin
    state_nxt     = state_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    v_nxt         = v_r;
    r_nxt         = r_r;
    e_nxt         = e_r;
    steps_nxt     = steps_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r;
    div_pend_nxt  = 1'b0;
    start_div_nxt = 1'b0;
    dreq.start    = start_div_r;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    emag          = e_r[SqW] ? QuoW'(-e_r) : QuoW'(e_r);
    step_mag      = '0;
    r_new         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dx_nxt    = dxs[16] ? 17'(-dxs) : 17'(dxs);
          dy_nxt    = dys[16] ? 17'(-dys) : 17'(dys);
          steps_nxt = '0;
          conv_nxt  = 1'b0;
          state_nxt = ST_SQ1;
        end
      end
      ST_SQ1: begin
        v_nxt     = prod[SumW-1:0];
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        v_nxt = v_r + prod[SumW-1:0];
        if ((v_r + prod[SumW-1:0]) == '0) begin
          r_nxt         = '0;
          conv_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          start_div_nxt = 1'b1;
          div_pend_nxt  = 1'b1;
          state_nxt     = ST_START;
        end
      end
      ST_START: begin
        // Start value V / 10 through the shared divider.
        dreq.dividend = QuoW'(v_r);
        dreq.divisor  = QuoW'(10);
        if (!div_busy && !div_pend_r && !start_div_r) begin
          r_nxt     = (quo == '0) ? RootW'(1) : quo[RootW-1:0];
          state_nxt = ST_CHECK_LIMIT;
        end
      end
      ST_CHECK_LIMIT: begin
        if (steps_r == max_iter_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          state_nxt = ST_ERR0;
        end
      end
      ST_ERR0: begin
        e_nxt         = $signed({1'b0, {(SqW-WW){1'b0}}, v_r, 16'd0})
                        - $signed({1'b0, prod});
        start_div_nxt = 1'b1;
        div_pend_nxt  = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        dreq.dividend = emag;
        dreq.divisor  = QuoW'({r_r, 1'b0});
        if (!div_busy && !div_pend_r && !start_div_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        step_mag = quo;
        if (e_r[SqW]) r_new = {1'b0, r_r} - (RootW+1)'(step_mag);
        else          r_new = {1'b0, r_r} + (RootW+1)'(step_mag);
        r_nxt     = r_new[RootW-1:0];
        steps_nxt = steps_r + 1'b1;
        state_nxt = ST_ERR1;
      end
      ST_ERR1: begin
        e_nxt     = $signed({1'b0, {(SqW-WW){1'b0}}, v_r, 16'd0})
                    - $signed({1'b0, prod});
        state_nxt = ST_CHECK_LIMIT;
        if ((e_nxt[SqW] ? (SqW+1)'(-e_nxt) : (SqW+1)'(e_nxt))
            <= (SqW+1)'(tol_r)) begin
          conv_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_pend_r  <= 1'b0;
      start_div_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_pend_r  <= div_pend_nxt;
      start_div_r <= start_div_nxt;
    end
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    v_r     <= v_nxt;
    r_r     <= r_nxt;
    e_r     <= e_nxt;
    steps_r <= steps_nxt;
    conv_r  <= conv_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_distance   = (r_r > RootW'(DistMax)) ? DistMax : r_r[DistW-1:0];
  assign out_steps_used = steps_r;
  assign out_converged  = conv_r;

  // A result is shown only in the done state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_DONE))
    else $error("result valid outside done state");

  // The step count never passes the limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (steps_r <= max_iter_r))
    else $error("step count beyond limit");

  // The divider is never restarted while it works.
  assert property (@(posedge clk) disable iff (!rst_n)
    start_div_r |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

/* rtl/core/edns_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on edns_pkg.
`timescale 1ns / 1ps
module edns_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  edns_pkg::div_req_t       req,
  output logic                     busy,
  output logic [edns_pkg::QuoW-1:0] quotient
);
  import edns_pkg::*;

  localparam int CntW = $clog2(QuoW + 1);

  logic [QuoW-1:0] rem_r, rem_nxt;
  logic [QuoW-1:0] quo_r, quo_nxt;
  logic [QuoW-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [QuoW:0]   trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[QuoW-1]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = CntW'(QuoW);
    end else if (cnt_r != '0) begin
      if (!trial[QuoW]) begin
        rem_nxt = trial[QuoW-1:0];
        quo_nxt = {quo_r[QuoW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[QuoW-2:0], quo_r[QuoW-1]};
        quo_nxt = {quo_r[QuoW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

/* tb/tb_euclidean_distance_newton_sqrt.sv */
// Self-checking testbench for euclidean_distance_newton_sqrt.
// Uses edns_pkg for widths and register indexes. It predicts each result
// with its own Newton square root and checks every result item in order.
`timescale 1ns / 1ps
module tb_euclidean_distance_newton_sqrt;
  import edns_pkg::*;

  // One pair of points as offered to the block.
  typedef struct {
    logic signed [15:0] ax, ay, bx, by;
  } point_pair_t;

  // One distance result as the block should return it.
  typedef struct {
    logic [DistW-1:0] dist_val;
    logic [StepW-1:0] steps;
    logic             conv;
  } dist_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegTolerance;
  logic [TolW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_p1_x = '0, in_p1_y = '0, in_p2_x = '0, in_p2_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DistW-1:0] out_distance;
  logic [StepW-1:0] out_steps_used;
  logic out_converged;

  euclidean_distance_newton_sqrt dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_p1_x(in_p1_x), .in_p1_y(in_p1_y), .in_p2_x(in_p2_x), .in_p2_y(in_p2_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_steps_used(out_steps_used),
    .out_converged(out_converged)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench's own copy of the two registers.
  logic [TolW-1:0]  tol_copy  = TolReset;
  logic [StepW-1:0] iter_copy = IterReset;

  point_pair_t  pending_pairs[$];
  dist_result_t expected_dists[$];
  int  fail_count = 0;
  int  in_gap_max = 4;
  int  out_gap_max = 4;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  longint cycle_count = 0;

  // Predicts the distance result of one pair under the current registers.
  // The square root runs on 64-bit values that wrap just as the block's
  // arithmetic would, with signed division truncating towards zero.
  function automatic dist_result_t newton_distance(point_pair_t p);
    longint da, db, e, dx;
    logic [63:0] v, w, r, mag;
    dist_result_t res;
    da = longint'(p.ax) - longint'(p.bx);
    db = longint'(p.ay) - longint'(p.by);
    v = 64'(da * da) + 64'(db * db);
    res.dist_val = '0;
    res.steps = '0;
    res.conv = 1'b0;
    if (v == 0) begin
      res.conv = 1'b1;
      return res;
    end
    w = v << 16;
    r = v / 10;
    // A tiny sum would give a zero start value and so a zero divisor.
    if (r == 0) r = 1;
    for (int i = 0; i < int'(iter_copy); i++) begin
      e = longint'(w) - longint'(r * r);
      dx = e / longint'(2 * r);
      r = 64'(longint'(r) + dx);
      res.steps = res.steps + 1'b1;
      e = longint'(w) - longint'(r * r);
      mag = (e < 0) ? 64'(-e) : 64'(e);
      if (mag <= {32'd0, tol_copy}) begin
        res.conv = 1'b1;
        break;
      end
    end
    // Only a run that did not converge can leave r above the output range.
    res.dist_val = (r > 64'(DistMax)) ? DistMax : r[DistW-1:0];
    return res;
  endfunction

  // Sender: takes items from the pending queue, with a random gap before
  // each one. The prediction is made when the block accepts the item.
  int in_gap = 0;
  always @(posedge clk) begin
    point_pair_t pp;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_dists.push_back(newton_distance('{in_p1_x, in_p1_y, in_p2_x, in_p2_y}));
        in_gap = $urandom_range(0, in_gap_max);
        next_valid = 1'b0;
      end
      // A stalled item is held unchanged until it is accepted.
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_pairs.size() > 0) begin
          pp = pending_pairs.pop_front();
          in_p1_x <= pp.ax;
          in_p1_y <= pp.ay;
          in_p2_x <= pp.bx;
          in_p2_y <= pp.by;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: checks each result item against the oldest prediction and
  // stalls at random. Once asked, it also holds off for a long stretch so
  // that the block fills up and stalls its input.
  int out_gap = 0;
  int hold_count = 0;
  always @(posedge clk) begin
    dist_result_t exp_res;
    logic next_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dists.size() == 0) begin
          $display("%0t: result item with none expected: dist=%0h steps=%0d conv=%0b",
                   $time, out_distance, out_steps_used, out_converged);
          fail_count++;
        end else begin
          exp_res = expected_dists.pop_front();
          if (out_distance !== exp_res.dist_val) begin
            $display("%0t: distance expected %0h actual %0h", $time, exp_res.dist_val,
                     out_distance);
            fail_count++;
          end
          if (out_steps_used !== exp_res.steps) begin
            $display("%0t: steps_used expected %0d actual %0d", $time, exp_res.steps,
                     out_steps_used);
            fail_count++;
          end
          if (out_converged !== exp_res.conv) begin
            $display("%0t: converged expected %0b actual %0b", $time, exp_res.conv,
                     out_converged);
            fail_count++;
          end
        end
        out_gap = $urandom_range(0, out_gap_max);
      end
      if (long_hold_req && !long_hold_done) begin
        hold_count++;
        if (hold_count >= 4000) long_hold_done = 1'b1;
        next_stall = 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // Watchdog: a generous bound on the whole run, well above the slowest
  // correct run with every item taking its full step count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 8000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes both registers while the block is idle and updates the copy.
  task automatic set_registers(logic [TolW-1:0] tol, logic [StepW-1:0] iters);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= RegTolerance;
    cfg_data <= tol;
    @(posedge clk);
    cfg_index <= RegMaxIter;
    cfg_data <= {26'd0, iters};
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_copy = tol;
    iter_copy = iters;
  endtask

  // Waits until every item is sent and every result has come back.
  task automatic drain;
    do begin
      @(posedge clk);
      #1;
    end while (pending_pairs.size() > 0 || in_valid || expected_dists.size() > 0);
  endtask

  task automatic add_pair(int ax, int ay, int bx, int by);
    point_pair_t p;
    p.ax = 16'(ax);
    p.ay = 16'(ay);
    p.bx = 16'(bx);
    p.by = 16'(by);
    pending_pairs.push_back(p);
  endtask

  // Random pairs: mostly full-range coordinates, some close points to reach
  // tiny sums, and some equal points for the zero sum.
  task automatic add_random_pairs(int count);
    int ax, ay, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      ax = $urandom_range(0, 65535);
      ay = $urandom_range(0, 65535);
      if (sel < 6)
        add_pair(ax, ay, $urandom_range(0, 65535), $urandom_range(0, 65535));
      else if (sel < 9)
        add_pair(ax, ay, ax + $urandom_range(0, 6) - 3, ay + $urandom_range(0, 6) - 3);
      else
        add_pair(ax, ay, ax, ay);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset registers: the zero sum, the tiny sum
    // that needs a start value of one, full-scale extremes, single axes and
    // negative differences.
    add_pair(0, 0, 0, 0);
    add_pair(-32768, 32767, -32768, 32767);
    add_pair(1, 0, 0, 0);
    add_pair(0, -1, 0, 0);
    add_pair(-32768, -32768, 32767, 32767);
    add_pair(32767, 32767, -32768, -32768);
    add_pair(32767, 0, -32768, 0);
    add_pair(0, -32768, 0, 32767);
    add_pair(256, 256, 0, 0);
    add_pair(-256, 512, 768, -1024);
    add_pair(3, 4, 0, 0);
    add_pair(-1, -1, -1, -1);
    add_pair(5, 0, 0, 0);
    drain();

    // Iteration limit of zero: no steps, the start value is returned.
    set_registers(TolReset, 6'd0);
    add_pair(-32768, -32768, 32767, 32767);
    add_pair(2, 0, 0, 0);
    add_pair(0, 0, 0, 0);
    add_random_pairs(20);
    drain();

    // Zero tolerance and the largest limit: most items never converge.
    set_registers(32'd0, 6'd63);
    add_random_pairs(30);
    drain();

    // Widest tolerance and a single step, with no idling on either side.
    in_gap_max = 0;
    out_gap_max = 0;
    set_registers(32'hFFFF_FFFF, 6'd1);
    add_random_pairs(150);
    drain();
    in_gap_max = 4;
    out_gap_max = 4;

    // Back to the reset values; the receiver holds off for a long stretch
    // while the sender keeps offering items.
    set_registers(TolReset, IterReset);
    long_hold_req = 1'b1;
    add_random_pairs(400);
    drain();

    // A few random register settings.
    for (int ph = 0; ph < 4; ph++) begin
      set_registers($urandom, 6'($urandom_range(1, 24)));
      add_random_pairs(50);
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/edns_pkg.sv
rtl/core/edns_div.sv
rtl/core/euclidean_distance_newton_sqrt.sv
tb/tb_euclidean_distance_newton_sqrt.sv
